### design/sai_pkg.sv
// Shared types and constants for the sparse approximate inverse column block.
// No dependencies; every other file imports this package.
`default_nettype none
package sai_pkg;

  localparam int MAX_NNZ_DFLT = 32;
  localparam int INDEX_BITS   = 16;
  localparam int DIV_STEPS    = 56;
  localparam int DIV_CNT_W    = 6;

  localparam logic signed [31:0] Q_ONE  = 32'sh0100_0000;
  localparam logic signed [31:0] Q_ZERO = 32'sh0000_0000;

  localparam logic REQ_PATTERN = 1'b0;
  localparam logic REQ_ENTRY   = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_PIV = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic               req_type;
    logic [15:0]        index;
    logic [4:0]         sub_row;
    logic signed [31:0] value;
    logic               last;
  } in_t;

  typedef struct packed {
    logic [4:0]         position;
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic               end_of_column;
  } out_t;

  typedef struct packed {
    logic       item_ld;
    logic       item_exec;
    logic       clr_wr;
    logic       sol_init_wr;
    logic       div_start;
    logic       sol_div_wr;
    logic       mul;
    logic       sol_sub_wr;
    logic       out_ld;
    logic       out_zero;
    logic [1:0] out_status;
    logic       out_eoc;
  } cmd_t;

  typedef struct packed {
    logic item_last;
    logic piv_zero;
    logic div_done;
    logic out_free;
    logic ovf;
  } stat_t;

endpackage
`default_nettype wire

### design/sai_div.sv
// Radix-2 restoring divider: (num * 2^24) / den, truncated toward zero, saturated.
// One quotient bit per cycle; uses sai_pkg.
`default_nettype none
module sai_div import sai_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] num,
  input  wire logic signed [31:0] den,
  output logic                    done,
  output logic signed [31:0]      quot
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 neg_r, neg_nxt;
  logic [31:0]          dmag_r, dmag_nxt;
  logic [31:0]          rem_r, rem_nxt;
  logic [DIV_STEPS-1:0] quo_r, quo_nxt;
  logic [32:0]          trial;
  logic [31:0]          nmag;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    dmag_nxt = dmag_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    nmag     = num[31] ? 32'(-num) : 32'(num);
    trial    = {rem_r, quo_r[DIV_STEPS-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS);
      neg_nxt  = num[31] ^ den[31];
      dmag_nxt = den[31] ? 32'(-den) : 32'(den);
      rem_nxt  = '0;
      quo_nxt  = {nmag, 24'd0};
    end else if (busy_r) begin
      if (trial >= {1'b0, dmag_r}) begin
        rem_nxt = 32'(trial - {1'b0, dmag_r});
        quo_nxt = {quo_r[DIV_STEPS-2:0], 1'b1};
      end else begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[DIV_STEPS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    neg_r  <= neg_nxt;
    dmag_r <= dmag_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
  end

  // saturate the magnitude back into signed 32 bits
  always_comb begin
    if (neg_r) begin
      if (quo_r > DIV_STEPS'(64'h8000_0000)) quot = 32'sh8000_0000;
      else quot = 32'(-quo_r[31:0]);
    end else begin
      if (quo_r > DIV_STEPS'(64'h7FFF_FFFF)) quot = 32'sh7FFF_FFFF;
      else quot = quo_r[31:0];
    end
  end

  assign done = done_r;

endmodule
`default_nettype wire

### design/sai_dp.sv
// Datapath: pattern registers, submatrix and solution memories, multiplier,
// divider and output register. Uses sai_pkg and sai_div.
`default_nettype none
module sai_dp import sai_pkg::*; #(
  parameter int MAX_NNZ = MAX_NNZ_DFLT,
  localparam int PW = (MAX_NNZ > 1) ? $clog2(MAX_NNZ) : 1,
  localparam int CW = $clog2(MAX_NNZ + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cmd_t          cmd,
  input  wire logic [PW-1:0] row_a,
  input  wire logic [PW-1:0] col_a,
  input  wire logic [PW-1:0] sol_a,
  input  wire in_t           in_data,
  output stat_t              stat,
  output logic [CW-1:0]      count,
  output logic               out_valid,
  input  wire logic          out_ready,
  output out_t               out_data
);

  logic signed [31:0]   mem [MAX_NNZ][MAX_NNZ];
  logic signed [31:0]   sol [MAX_NNZ];
  logic [INDEX_BITS-1:0] pidx_r [MAX_NNZ];

  in_t                  item_r;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 ovf_r, ovf_nxt;
  logic signed [31:0]   mem_q, sol_q;
  logic signed [31:0]   xj_r, soli_r;
  logic signed [63:0]   prod_r;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_r;

  logic [MAX_NNZ-1:0]   hit;
  logic [PW-1:0]        hit_pos;
  logic                 row_ok;
  logic                 ent_wr;
  logic                 mem_we;
  logic [PW-1:0]        mw_row, mw_col;
  logic signed [31:0]   mw_data;
  logic                 sol_we;
  logic signed [31:0]   sol_wdata;
  logic signed [40:0]   diff;
  logic signed [31:0]   diff_sat;
  logic                 div_done;
  logic signed [31:0]   div_q;

  sai_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (sol_q),
    .den   (mem_q),
    .done  (div_done),
    .quot  (div_q)
  );

  // lowest pattern position whose index matches the entry's column
  always_comb begin
    hit_pos = '0;
    for (int p = 0; p < MAX_NNZ; p++) begin
      hit[p] = (8'(p) < 8'(count_r)) && (pidx_r[p] == item_r.index[INDEX_BITS-1:0]);
    end
    for (int p = MAX_NNZ - 1; p >= 0; p--) begin
      if (hit[p]) hit_pos = PW'(p);
    end
    row_ok = 8'(item_r.sub_row) < 8'(count_r);
    ent_wr = cmd.item_exec && (item_r.req_type == REQ_ENTRY) && row_ok && (|hit);
  end

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (cmd.clr_wr) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (cmd.item_exec && item_r.req_type == REQ_PATTERN) begin
      if (count_r < CW'(MAX_NNZ)) count_nxt = count_r + CW'(1);
      else ovf_nxt = 1'b1;
    end
  end

  always_comb begin
    mem_we  = cmd.clr_wr || ent_wr;
    mw_row  = cmd.clr_wr ? row_a : PW'(item_r.sub_row);
    mw_col  = cmd.clr_wr ? col_a : hit_pos;
    mw_data = cmd.clr_wr ? Q_ZERO : item_r.value;
  end

  always_comb begin
    diff = 41'(soli_r) - 41'($signed(prod_r[63:24]));
    if (diff > 41'sh0_7FFF_FFFF) diff_sat = 32'sh7FFF_FFFF;
    else if (diff < -41'sh0_8000_0000) diff_sat = 32'sh8000_0000;
    else diff_sat = diff[31:0];
  end

  always_comb begin
    sol_we    = cmd.sol_init_wr || cmd.sol_div_wr || cmd.sol_sub_wr;
    sol_wdata = diff_sat;
    if (cmd.sol_init_wr) sol_wdata = (sol_a == '0) ? Q_ONE : Q_ZERO;
    else if (cmd.sol_div_wr) sol_wdata = div_q;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mw_row][mw_col] <= mw_data;
    mem_q <= mem[row_a][col_a];
  end

  always_ff @(posedge clk) begin
    if (sol_we) sol[sol_a] <= sol_wdata;
    sol_q <= sol[sol_a];
  end

  always_ff @(posedge clk) begin
    if (cmd.item_exec && item_r.req_type == REQ_PATTERN && count_r < CW'(MAX_NNZ)) begin
      pidx_r[count_r[PW-1:0]] <= item_r.index[INDEX_BITS-1:0];
    end
    if (cmd.item_ld) item_r <= in_data;
    if (cmd.sol_div_wr) xj_r <= div_q;
    if (cmd.mul) begin
      prod_r <= xj_r * mem_q;
      soli_r <= sol_q;
    end
  end

  assign out_valid_nxt = cmd.out_ld ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (cmd.out_ld) begin
      out_r.position      <= 5'(sol_a);
      out_r.result_value  <= cmd.out_zero ? Q_ZERO : sol_q;
      out_r.status        <= cmd.out_status;
      out_r.end_of_column <= cmd.out_eoc;
    end
  end

  assign stat.item_last = item_r.last;
  assign stat.piv_zero  = (mem_q == Q_ZERO);
  assign stat.div_done  = div_done;
  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.ovf       = ovf_r;
  assign count          = count_r;
  assign out_valid      = out_valid_r;
  assign out_data       = out_r;

endmodule
`default_nettype wire

### design/sai_ctrl.sv
// Controller: sequences load, clear sweep, forward solve and result emission.
// Uses sai_pkg; drives sai_dp through cmd_t and addresses.
`default_nettype none
module sai_ctrl import sai_pkg::*; #(
  parameter int MAX_NNZ = MAX_NNZ_DFLT,
  localparam int PW = (MAX_NNZ > 1) ? $clog2(MAX_NNZ) : 1,
  localparam int CW = $clog2(MAX_NNZ + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire stat_t         stat,
  input  wire logic [CW-1:0] count,
  output cmd_t               cmd,
  output logic [PW-1:0]      row_a,
  output logic [PW-1:0]      col_a,
  output logic [PW-1:0]      sol_a
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_EXEC = 4'd2;
  localparam logic [3:0] S_FIN  = 4'd3;
  localparam logic [3:0] S_INIT = 4'd4;
  localparam logic [3:0] S_PRD  = 4'd5;
  localparam logic [3:0] S_PIV  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_URD  = 4'd8;
  localparam logic [3:0] S_MUL  = 4'd9;
  localparam logic [3:0] S_SUB  = 4'd10;
  localparam logic [3:0] S_ERD  = 4'd11;
  localparam logic [3:0] S_ELD  = 4'd12;
  localparam logic [3:0] S_SPC  = 4'd13;

  logic [3:0]    state_r, state_nxt;
  logic [PW-1:0] r_r, r_nxt, c_r, c_nxt, i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [CW-1:0] bad_r, bad_nxt, clr_n_r, clr_n_nxt;
  logic [CW-1:0] r1, c1, i1, j1, k1;

  assign r1 = CW'(r_r) + CW'(1);
  assign c1 = CW'(c_r) + CW'(1);
  assign i1 = CW'(i_r) + CW'(1);
  assign j1 = CW'(j_r) + CW'(1);
  assign k1 = CW'(k_r) + CW'(1);

  always_comb begin
    state_nxt = state_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    bad_nxt   = bad_r;
    clr_n_nxt = clr_n_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (c1 >= clr_n_r) begin
          c_nxt = '0;
          r_nxt = r_r + PW'(1);
          if (r1 >= clr_n_r) begin
            r_nxt     = '0;
            state_nxt = S_IDLE;
          end
        end else begin
          c_nxt = c_r + PW'(1);
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.item_ld = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.item_exec = 1'b1;
        state_nxt     = stat.item_last ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        k_nxt = '0;
        if (stat.ovf || count == '0) state_nxt = S_SPC;
        else state_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.sol_init_wr = 1'b1;
        if (k1 == count) begin
          j_nxt     = '0;
          state_nxt = S_PRD;
        end else begin
          k_nxt = k_r + PW'(1);
        end
      end
      S_PRD: state_nxt = S_PIV;
      S_PIV: begin
        if (stat.piv_zero) begin
          bad_nxt   = CW'(j_r);
          k_nxt     = '0;
          state_nxt = S_ERD;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.sol_div_wr = 1'b1;
          if (j1 < count) begin
            i_nxt     = j_r + PW'(1);
            state_nxt = S_URD;
          end else begin
            bad_nxt   = count;
            k_nxt     = '0;
            state_nxt = S_ERD;
          end
        end
      end
      S_URD: state_nxt = S_MUL;
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SUB;
      end
      S_SUB: begin
        cmd.sol_sub_wr = 1'b1;
        if (i1 < count) begin
          i_nxt     = i_r + PW'(1);
          state_nxt = S_URD;
        end else begin
          j_nxt     = j_r + PW'(1);
          state_nxt = S_PRD;
        end
      end
      S_ERD: state_nxt = S_ELD;
      S_ELD: begin
        if (stat.out_free) begin
          cmd.out_ld     = 1'b1;
          cmd.out_zero   = CW'(k_r) >= bad_r;
          cmd.out_status = (CW'(k_r) >= bad_r) ? ST_ZERO_PIV : ST_OK;
          cmd.out_eoc    = (k1 == count);
          if (k1 == count) begin
            clr_n_nxt = count;
            r_nxt     = '0;
            c_nxt     = '0;
            state_nxt = S_CLR;
          end else begin
            k_nxt     = k_r + PW'(1);
            state_nxt = S_ERD;
          end
        end
      end
      S_SPC: begin
        if (stat.out_free) begin
          cmd.out_ld     = 1'b1;
          cmd.out_zero   = 1'b1;
          cmd.out_status = stat.ovf ? ST_OVERFLOW : ST_OK;
          cmd.out_eoc    = 1'b1;
          clr_n_nxt      = count;
          r_nxt          = '0;
          c_nxt          = '0;
          state_nxt      = S_CLR;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  // memory addresses follow the state; reads are registered and land in the next cycle
  always_comb begin
    row_a = j_r;
    col_a = j_r;
    sol_a = j_r;
    if (state_r == S_CLR) begin
      row_a = r_r;
      col_a = c_r;
    end else if (state_r == S_URD || state_r == S_MUL || state_r == S_SUB) begin
      row_a = i_r;
      sol_a = i_r;
    end else if (state_r == S_INIT || state_r == S_ERD || state_r == S_ELD ||
                 state_r == S_SPC || state_r == S_FIN) begin
      sol_a = k_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_n_r <= CW'(MAX_NNZ);
      r_r     <= '0;
      c_r     <= '0;
    end else begin
      state_r <= state_nxt;
      clr_n_r <= clr_n_nxt;
      r_r     <= r_nxt;
      c_r     <= c_nxt;
    end
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    bad_r <= bad_nxt;
  end

endmodule
`default_nettype wire

### design/sparse_approx_inverse_column.sv
// Load items: accept, then pattern match and store write. Last item: init,
// per pivot a read, zero check and divide, per elimination update (m(m-1)/2
// of them) a read, multiply and subtract, then each result emitted, then an
// m*m submatrix clearing sweep. After reset a MAX_NNZ*MAX_NNZ sweep runs
// with in_ready low. The 1-bit-per-cycle divider sets pivot cost.
`default_nettype none
module sparse_approx_inverse_column import sai_pkg::*; #(
  parameter int MAX_NNZ = MAX_NNZ_DFLT
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  localparam int PW = (MAX_NNZ > 1) ? $clog2(MAX_NNZ) : 1;
  localparam int CW = $clog2(MAX_NNZ + 1);

  cmd_t          cmd;
  stat_t         stat;
  logic [CW-1:0] count;
  logic [PW-1:0] row_a, col_a, sol_a;

  sai_ctrl #(.MAX_NNZ(MAX_NNZ)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .count    (count),
    .cmd      (cmd),
    .row_a    (row_a),
    .col_a    (col_a),
    .sol_a    (sol_a)
  );

  sai_dp #(.MAX_NNZ(MAX_NNZ)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .row_a     (row_a),
    .col_a     (col_a),
    .sol_a     (sol_a),
    .in_data   (in_data),
    .stat      (stat),
    .count     (count),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
